/* rtl/assert_macros.svh */
// Assertion helpers: full checks in simulation, empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds, consequent holds in the same cycle.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent holds, consequent holds in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`else

`define CHK_SAME(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/obdp_pkg.sv */
`timescale 1ns / 1ps

package obdp_pkg;

  localparam int MAX_LINE_BYTES_DEF = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODATA  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // Search strings, first character in the top byte, zero padded below
  localparam int PAT_MAX  = 17;
  localparam int PAT_BITS = 8 * PAT_MAX;
  localparam logic [PAT_BITS-1:0] PAT_NODATA = {"NO DATA", 80'h0};
  localparam logic [PAT_BITS-1:0] PAT_UNABLE = "UNABLE TO CONNECT";
  localparam logic [PAT_BITS-1:0] PAT_ERROR  = {"ERROR", 96'h0};
  localparam logic [4:0] LEN_NODATA = 5'd7;
  localparam logic [4:0] LEN_UNABLE = 5'd17;
  localparam logic [4:0] LEN_ERROR  = 5'd5;

  // Bit positions in the found flags
  localparam int F_NODATA = 0;
  localparam int F_QMARK  = 1;
  localparam int F_UNABLE = 2;
  localparam int F_ERROR  = 3;

  // Reply job handed from the parser to the result side
  typedef struct packed {
    logic       start;
    logic       bank;
    status_t    status;
    logic [7:0] mode;
    logic [7:0] pid;
  } job_t;

  // Line buffer write
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } mem_wr_t;

  // One result word
  typedef struct packed {
    status_t    status;
    logic [7:0] mode;
    logic [7:0] pid;
    logic [7:0] data;
    logic       data_valid;
    logic       last;
  } res_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // One step of a string search; the first letter occurs once per string,
  // so a mismatch can only restart on that letter.
  function automatic logic [4:0] match_next(input logic [4:0] prog, input logic [7:0] c,
                                            input logic [PAT_BITS-1:0] pat,
                                            input logic [4:0] len);
    logic [4:0] p;
    logic [7:0] pc;
    logic [7:0] sel;
    pc  = 8'h00;
    sel = 8'h00;
    if (prog < len) begin
      sel = 8'(8 * (PAT_MAX - 1 - int'(prog)));
      pc  = pat[sel +: 8];
    end
    if (prog < len && pc == c) begin
      p = 5'(prog + 5'd1);
    end else begin
      p = (pat[PAT_BITS-1 -: 8] == c) ? 5'd1 : 5'd0;
    end
    if (p >= len) begin
      p = len;
    end
    return p;
  endfunction

endpackage

/* rtl/obdp_ifs.sv */
`timescale 1ns / 1ps

// Character channel
interface obdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       end_of_reply;

  modport source (output valid, output char_code, output char_valid,
                  output end_of_reply, input ready);
  modport sink (input valid, input char_code, input char_valid,
                input end_of_reply, output ready);
endinterface

// Result channel
interface obdp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] mode_byte;
  logic [7:0] pid_byte;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last_result;

  modport source (output valid, output status, output mode_byte, output pid_byte,
                  output data_byte, output data_valid, output last_result, input ready);
  modport sink (input valid, input status, input mode_byte, input pid_byte,
                input data_byte, input data_valid, input last_result, output ready);
endinterface

/* rtl/obdp_parser.sv */
`timescale 1ns / 1ps

module obdp_parser import obdp_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic [7:0]                          char_code,
  input  logic                                char_valid,
  input  logic                                end_of_reply,
  output mem_wr_t                             wr,
  output logic [$clog2(MAX_LINE_BYTES)-1:0]   wr_addr,
  output job_t                                job,
  output logic [$clog2(MAX_LINE_BYTES+2)-1:0] job_cnt
);

  localparam int CW = $clog2(MAX_LINE_BYTES + 2);
  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LINE_BYTES);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    hn_r, hn_nxt;
  logic          np_r, np_nxt;
  logic          hpu_r, hpu_nxt;
  logic          pe_r, pe_nxt;
  logic          lbp_r, lbp_nxt;
  logic          prompt_r, prompt_nxt;
  logic          content_r, content_nxt;
  logic [2:0]    nd_r, nd_nxt;
  logic [4:0]    un_r, un_nxt;
  logic [2:0]    er_r, er_nxt;
  logic [3:0]    found_r, found_nxt;
  logic          bank_r, bank_nxt;
  logic [7:0]    b0_r, b0_nxt;
  logic [7:0]    b1_r, b1_nxt;

  logic [4:0] hx;
  logic [4:0] p_nd, p_un, p_er;
  logic       ws;
  logic       do_store;
  logic [7:0] st_val;
  status_t    st;

  assign hx = hex_val(char_code);
  assign ws = (char_code == CH_SPACE) || (char_code == CH_CR) || (char_code == CH_LF);
  assign p_nd = match_next({2'b00, nd_r}, char_code, PAT_NODATA, LEN_NODATA);
  assign p_un = match_next(un_r, char_code, PAT_UNABLE, LEN_UNABLE);
  assign p_er = match_next({2'b00, er_r}, char_code, PAT_ERROR, LEN_ERROR);

  // Per-character update, then the end-of-reply verdict
  always_comb begin
    cnt_nxt     = cnt_r;
    hn_nxt      = hn_r;
    np_nxt      = np_r;
    hpu_nxt     = hpu_r;
    pe_nxt      = pe_r;
    lbp_nxt     = lbp_r;
    prompt_nxt  = prompt_r;
    content_nxt = content_r;
    nd_nxt      = nd_r;
    un_nxt      = un_r;
    er_nxt      = er_r;
    found_nxt   = found_r;
    bank_nxt    = bank_r;
    b0_nxt      = b0_r;
    b1_nxt      = b1_r;
    do_store    = 1'b0;
    st_val      = 8'h00;
    wr          = '0;
    wr.bank     = bank_r;
    wr_addr     = '0;
    job         = '0;
    job.status  = ST_OK;
    job_cnt     = '0;

    if (take && char_valid && !prompt_r) begin
      if (char_code == CH_PROMPT) begin
        prompt_nxt = 1'b1;
      end else begin
        // string searches
        if (!found_r[F_NODATA]) begin
          nd_nxt = p_nd[2:0];
          if (p_nd == LEN_NODATA) found_nxt[F_NODATA] = 1'b1;
        end
        if (!found_r[F_UNABLE]) begin
          un_nxt = p_un;
          if (p_un == LEN_UNABLE) found_nxt[F_UNABLE] = 1'b1;
        end
        if (!found_r[F_ERROR]) begin
          er_nxt = p_er[2:0];
          if (p_er == LEN_ERROR) found_nxt[F_ERROR] = 1'b1;
        end
        if (char_code == CH_QMARK) found_nxt[F_QMARK] = 1'b1;

        if (ws) begin
          // whitespace closes a half pair
          if (char_code == CH_CR) lbp_nxt = 1'b1;
          if (np_r) begin
            do_store = 1'b1;
            st_val   = {4'h0, hn_r};
            np_nxt   = 1'b0;
            hpu_nxt  = 1'b1;
          end
        end else begin
          content_nxt = 1'b1;
          // content after CR starts a fresh line
          if (lbp_r) begin
            cnt_nxt = '0;
            np_nxt  = 1'b0;
            pe_nxt  = 1'b0;
            lbp_nxt = 1'b0;
          end
          hpu_nxt = 1'b0;
          if (!pe_nxt) begin
            if (np_nxt) begin
              do_store = 1'b1;
              st_val   = hx[4] ? {hn_r, hx[3:0]} : {4'h0, hn_r};
              np_nxt   = 1'b0;
            end else if (hx[4]) begin
              hn_nxt = hx[3:0];
              np_nxt = 1'b1;
            end else begin
              pe_nxt = 1'b1;
            end
          end
        end
      end
    end

    // byte store: first two bytes in registers, the rest in the line buffer
    if (do_store) begin
      if (cnt_nxt < CNT_MAX) begin
        priority if (cnt_nxt == CW'(0)) begin
          b0_nxt = st_val;
        end else if (cnt_nxt == CW'(1)) begin
          b1_nxt = st_val;
        end else begin
          wr.en   = 1'b1;
          wr.data = st_val;
          wr_addr = cnt_nxt[AW-1:0];
        end
      end
      if (cnt_nxt <= CNT_MAX) cnt_nxt = CW'(cnt_nxt + CW'(1));
    end

    // verdict, in order of precedence
    priority if (!content_nxt) begin
      st = ST_NODATA;
    end else if (found_nxt[F_NODATA]) begin
      st = ST_NODATA;
    end else if (found_nxt[F_QMARK]) begin
      st = ST_INVALID;
    end else if (found_nxt[F_UNABLE]) begin
      st = ST_NODATA;
    end else if (found_nxt[F_ERROR]) begin
      st = ST_INVALID;
    end else if (pe_nxt || np_nxt || hpu_nxt) begin
      st = ST_INVALID;
    end else if (cnt_nxt < CW'(2) || cnt_nxt > CNT_MAX) begin
      st = ST_INVALID;
    end else begin
      st = ST_OK;
    end

    // end of reply: hand over the job and clear for the next reply
    if (take && end_of_reply) begin
      job.start   = 1'b1;
      job.bank    = bank_r;
      job.status  = st;
      job.mode    = (st == ST_OK) ? b0_nxt : 8'h00;
      job.pid     = (st == ST_OK) ? b1_nxt : 8'h00;
      job_cnt     = cnt_nxt;
      cnt_nxt     = '0;
      hn_nxt      = 4'h0;
      np_nxt      = 1'b0;
      hpu_nxt     = 1'b0;
      pe_nxt      = 1'b0;
      lbp_nxt     = 1'b0;
      prompt_nxt  = 1'b0;
      content_nxt = 1'b0;
      nd_nxt      = '0;
      un_nxt      = '0;
      er_nxt      = '0;
      found_nxt   = '0;
      bank_nxt    = ~bank_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      hn_r      <= 4'h0;
      np_r      <= 1'b0;
      hpu_r     <= 1'b0;
      pe_r      <= 1'b0;
      lbp_r     <= 1'b0;
      prompt_r  <= 1'b0;
      content_r <= 1'b0;
      nd_r      <= '0;
      un_r      <= '0;
      er_r      <= '0;
      found_r   <= '0;
      bank_r    <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      hn_r      <= hn_nxt;
      np_r      <= np_nxt;
      hpu_r     <= hpu_nxt;
      pe_r      <= pe_nxt;
      lbp_r     <= lbp_nxt;
      prompt_r  <= prompt_nxt;
      content_r <= content_nxt;
      nd_r      <= nd_nxt;
      un_r      <= un_nxt;
      er_r      <= er_nxt;
      found_r   <= found_nxt;
      bank_r    <= bank_nxt;
    end
  end

  // mode and pid bytes of the line being read
  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule

/* rtl/obdp_emitter.sv */
`timescale 1ns / 1ps

module obdp_emitter import obdp_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mem_wr_t                             wr,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0]   wr_addr,
  input  job_t                                job,
  input  logic [$clog2(MAX_LINE_BYTES+2)-1:0] job_cnt,
  output logic                                job_busy,
  output logic                                job_free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output res_t                                out_res
);

  localparam int CW = $clog2(MAX_LINE_BYTES + 2);
  localparam int AW = $clog2(MAX_LINE_BYTES);

  // two line buffers, one filling while the other drains
  logic [7:0] mem [2**(AW+1)];

  logic          job_v_r;
  logic          job_bank_r;
  status_t       job_status_r;
  logic [7:0]    job_mode_r;
  logic [7:0]    job_pid_r;
  logic [CW-1:0] job_cnt_r;
  logic [CW-1:0] job_k_r;

  logic          s1_v_r;
  res_t          s1_res_r;
  logic [7:0]    rd_data_r;

  logic          out_v_r;
  res_t          out_res_r;

  logic          out_free;
  logic          s1_adv;
  logic          issue;
  logic          single;
  logic          last_k;
  logic [CW-1:0] k_inc;
  res_t          s1_word;

  assign out_free = !out_v_r || out_ready;
  assign s1_adv   = s1_v_r && out_free;
  assign issue    = job_v_r && (!s1_v_r || s1_adv);
  assign single   = (job_status_r != ST_OK) || (job_cnt_r == CW'(2));
  assign k_inc    = CW'(job_k_r + CW'(1));
  assign last_k   = single || (k_inc == job_cnt_r);

  // read stage word with the buffer byte merged in
  always_comb begin
    s1_word      = s1_res_r;
    s1_word.data = s1_res_r.data_valid ? rd_data_r : 8'h00;
  end

  // line buffer write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr_addr}] <= wr.data;
    end
    if (issue) begin
      rd_data_r <= mem[{job_bank_r, job_k_r[AW-1:0]}];
    end
  end

  // job sequencer, read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job.start) begin
        job_v_r <= 1'b1;
      end else if (issue && last_k) begin
        job_v_r <= 1'b0;
      end
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (job.start) begin
      job_bank_r   <= job.bank;
      job_status_r <= job.status;
      job_mode_r   <= job.mode;
      job_pid_r    <= job.pid;
      job_cnt_r    <= job_cnt;
      job_k_r      <= CW'(2);
    end else if (issue) begin
      job_k_r <= k_inc;
    end
    if (issue) begin
      s1_res_r.status     <= job_status_r;
      s1_res_r.mode       <= job_mode_r;
      s1_res_r.pid        <= job_pid_r;
      s1_res_r.data       <= 8'h00;
      s1_res_r.data_valid <= !single;
      s1_res_r.last       <= last_k;
    end
    if (s1_adv) begin
      out_res_r <= s1_word;
    end
  end

  // a new job may start in the cycle the last read of the old one issues
  assign job_busy  = job_v_r;
  assign job_free  = !job_v_r || (issue && last_k);
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

/* rtl/obd_ascii_response_parser.sv */
`timescale 1ns / 1ps

// Parser for the ASCII hex reply of a vehicle diagnostic adapter.
// in_ch carries one character word per handshake (char_code, char_valid)
// and end_of_reply on the last word of a reply; char_valid 0 words only
// count when they close the reply. One character is taken every cycle
// that in_ch.ready is high. At end_of_reply the reply is judged (search
// strings, hex pairing, byte count); its results leave on out_ch: one word
// per payload byte, or a single word for a bare mode/pid or a no-data or
// invalid verdict, with last_result on the final one. The first result
// passes the job registers, the read stage and the output register; the
// rest follow one per cycle while out_ch is not stalled, paced by the one
// read port of the line buffer. The next reply's characters are taken
// meanwhile into the second line buffer; only its closing word waits until
// the last read of the previous reply has issued. A stalled out_ch holds
// its word and backs up through the read stage. Reset clears all parsing
// state and empties the result side; the line buffers need no clearing.
module obd_ascii_response_parser import obdp_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  obdp_in_if.sink        in_ch,
  obdp_out_if.source     out_ch
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_LINE_BYTES + 2);
  localparam int AW = $clog2(MAX_LINE_BYTES);

  logic          take;
  logic          job_busy;
  logic          job_free;
  mem_wr_t       wr;
  logic [AW-1:0] wr_addr;
  job_t          job;
  logic [CW-1:0] job_cnt;
  logic          out_valid;
  res_t          out_res;

  // closing word waits while the previous reply still drains
  assign in_ch.ready = !(in_ch.end_of_reply && !job_free);
  assign take        = in_ch.valid && in_ch.ready;

  obdp_parser #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_code   (in_ch.char_code),
    .char_valid  (in_ch.char_valid),
    .end_of_reply(in_ch.end_of_reply),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .job         (job),
    .job_cnt     (job_cnt)
  );

  obdp_emitter #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .job      (job),
    .job_cnt  (job_cnt),
    .job_busy (job_busy),
    .job_free (job_free),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_res  (out_res)
  );

  // result channel
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_res.status;
  assign out_ch.mode_byte   = out_res.mode;
  assign out_ch.pid_byte    = out_res.pid;
  assign out_ch.data_byte   = out_res.data;
  assign out_ch.data_valid  = out_res.data_valid;
  assign out_ch.last_result = out_res.last;

  // checks
  `CHK_SAME(a_no_job_overlap, clk, rst_n, job.start, job_free)
  `CHK_NEXT(a_job_starts, clk, rst_n, job.start, job_busy)
  `CHK_SAME(a_verdict_single, clk, rst_n, out_valid && (out_res.status != ST_OK),
            out_res.last && !out_res.data_valid)
  `CHK_SAME(a_payload_ok, clk, rst_n, out_valid && out_res.data_valid,
            out_res.status == ST_OK)

endmodule

/* tb/obd_reply_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the reply parser, works out the result words
// each reply should give and compares them, in order, with what comes out.
module obd_reply_checker import obdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  obdp_in_if   in_mon,
  obdp_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  localparam int LINE_MAX = MAX_LINE_BYTES_DEF;
  localparam int LB_AW    = $clog2(LINE_MAX);

  string txt_nodata = "NO DATA";
  string txt_unable = "UNABLE TO CONNECT";
  string txt_error  = "ERROR";

  // Parse state of the reply in progress
  logic [7:0] line_buf [LINE_MAX];
  int         line_cnt;
  logic [3:0] hi_digit;
  bit         digit_pending;
  bit         digit_unconfirmed;
  bit         pair_bad;
  bit         cr_seen;
  bit         prompt_seen;
  bit         content_seen;
  int         prog_nodata;
  int         prog_unable;
  int         prog_error;
  logic [3:0] found;

  res_t expected_words [$];

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    $display("tb: mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  // Search progress; first letters never recur in a string, so a miss
  // restarts at most at one
  function automatic int next_progress(int prog, string pat, logic [7:0] c);
    if (prog < pat.len() && pat[prog] == c) return prog + 1;
    return (pat[0] == c) ? 1 : 0;
  endfunction

  task automatic clear_reply();
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    line_cnt          = 0;
    hi_digit          = 4'h0;
    digit_pending     = 1'b0;
    digit_unconfirmed = 1'b0;
    pair_bad          = 1'b0;
    cr_seen           = 1'b0;
    prompt_seen       = 1'b0;
    content_seen      = 1'b0;
    prog_nodata       = 0;
    prog_unable       = 0;
    prog_error        = 0;
    found             = 4'h0;
  endtask

  // Count saturates one past the buffer size
  task automatic store_byte(logic [7:0] b);
    if (line_cnt < LINE_MAX) line_buf[LB_AW'(line_cnt)] = b;
    if (line_cnt <= LINE_MAX) line_cnt++;
  endtask

  task automatic take_char(logic [7:0] c);
    int v;
    if (prompt_seen) return;
    if (c == CH_PROMPT) begin
      prompt_seen = 1'b1;
      return;
    end

    // String searches
    if (!found[F_NODATA]) begin
      prog_nodata = next_progress(prog_nodata, txt_nodata, c);
      if (prog_nodata == txt_nodata.len()) found[F_NODATA] = 1'b1;
    end
    if (!found[F_UNABLE]) begin
      prog_unable = next_progress(prog_unable, txt_unable, c);
      if (prog_unable == txt_unable.len()) found[F_UNABLE] = 1'b1;
    end
    if (!found[F_ERROR]) begin
      prog_error = next_progress(prog_error, txt_error, c);
      if (prog_error == txt_error.len()) found[F_ERROR] = 1'b1;
    end
    if (c == CH_QMARK) found[F_QMARK] = 1'b1;

    // Whitespace closes a half pair, which stays in doubt
    if (c == CH_SPACE || c == CH_CR || c == CH_LF) begin
      if (c == CH_CR) cr_seen = 1'b1;
      if (digit_pending) begin
        store_byte({4'h0, hi_digit});
        digit_pending     = 1'b0;
        digit_unconfirmed = 1'b1;
      end
      return;
    end

    content_seen = 1'b1;
    // Content after a CR starts the line afresh
    if (cr_seen) begin
      line_cnt      = 0;
      digit_pending = 1'b0;
      pair_bad      = 1'b0;
      cr_seen       = 1'b0;
    end
    digit_unconfirmed = 1'b0;
    if (pair_bad) return;

    v = hex_value(c);
    if (digit_pending) begin
      if (v >= 0) store_byte({hi_digit, v[3:0]});
      else store_byte({4'h0, hi_digit});
      digit_pending = 1'b0;
    end else if (v >= 0) begin
      hi_digit      = v[3:0];
      digit_pending = 1'b1;
    end else begin
      pair_bad = 1'b1;
    end
  endtask

  function automatic status_t reply_status();
    if (!content_seen) return ST_NODATA;
    if (found[F_NODATA]) return ST_NODATA;
    if (found[F_QMARK]) return ST_INVALID;
    if (found[F_UNABLE]) return ST_NODATA;
    if (found[F_ERROR]) return ST_INVALID;
    if (pair_bad || digit_pending || digit_unconfirmed) return ST_INVALID;
    if (line_cnt < 2 || line_cnt > LINE_MAX) return ST_INVALID;
    return ST_OK;
  endfunction

  // Verdict of the reply as result words
  task automatic close_reply();
    status_t st;
    res_t    w;
    st = reply_status();
    if (st != ST_OK || line_cnt == 2) begin
      w        = '0;
      w.status = st;
      w.last   = 1'b1;
      if (st == ST_OK) begin
        w.mode = line_buf[0];
        w.pid  = line_buf[1];
      end
      expected_words = {expected_words, w};
    end else begin
      for (int k = 2; k < line_cnt; k++) begin
        w            = '0;
        w.status     = ST_OK;
        w.mode       = line_buf[0];
        w.pid        = line_buf[1];
        w.data       = line_buf[LB_AW'(k)];
        w.data_valid = 1'b1;
        w.last       = (k + 1 == line_cnt);
        expected_words = {expected_words, w};
      end
    end
    clear_reply();
  endtask

  task automatic check_word();
    res_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with nothing expected, status",
                      int'(out_mon.status), -1);
      return;
    end
    want = expected_words.pop_front();
    results_seen++;
    if (out_mon.status !== want.status)
      report_mismatch("status", int'(out_mon.status), int'(want.status));
    if (out_mon.mode_byte !== want.mode)
      report_mismatch("mode_byte", int'(out_mon.mode_byte), int'(want.mode));
    if (out_mon.pid_byte !== want.pid)
      report_mismatch("pid_byte", int'(out_mon.pid_byte), int'(want.pid));
    if (out_mon.data_byte !== want.data)
      report_mismatch("data_byte", int'(out_mon.data_byte), int'(want.data));
    if (out_mon.data_valid !== want.data_valid)
      report_mismatch("data_valid", int'(out_mon.data_valid), int'(want.data_valid));
    if (out_mon.last_result !== want.last)
      report_mismatch("last_result", int'(out_mon.last_result), int'(want.last));
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_reply();
      expected_words.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.char_valid) take_char(in_mon.char_code);
        if (in_mon.end_of_reply) close_reply();
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/obd_ascii_response_parser_tb.sv */
`timescale 1ns / 1ps

// Drives adapter replies into the parser under several pacing mixes and
// gives the verdict; the checker beside the block does the predicting.
module obd_ascii_response_parser_tb;
  import obdp_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 105;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_PHASES     = 4;
  localparam int PW           = $clog2(N_PHASES);
  localparam int SRC_IDLE   [N_PHASES] = '{0, 84, 0, 32};
  localparam int SINK_STALL [N_PHASES] = '{0, 0, 84, 32};

  typedef enum int {
    RK_OK, RK_TEXT, RK_BLANK, RK_LONE, RK_BAD_SECOND,
    RK_BAD_FIRST, RK_LONG, RK_NOISE, RK_TWO_LINES
  } reply_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  obdp_in_if  in_ch ();
  obdp_out_if out_ch ();

  int fail_count;
  int pending;
  int results_seen;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int replies_sent   = 0;
  int idle_cycles    = 0;
  logic [7:0] reply_chars [$];

  obd_ascii_response_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  obd_reply_checker reply_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: watchdog, no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 6))
      0:       return "G";
      1:       return "z";
      2:       return 8'h09;
      3:       return 8'h00;
      4:       return 8'h7F;
      5:       return 8'hFF;
      default: return ":";
    endcase
  endfunction

  // Mostly short lines, now and then up to a full buffer
  function automatic int byte_count();
    return ($urandom_range(99) < 85) ? $urandom_range(2, 6) : $urandom_range(2, 16);
  endfunction

  // Adapter messages; '|' stands for CR
  function automatic string canned_text(int sel);
    case (sel)
      0:       return "NO DATA";
      1:       return "SEARCHING...|NO DATA";
      2:       return "?";
      3:       return "41 0C ?";
      4:       return "UNABLE TO CONNECT";
      5:       return "BUS INIT: ...ERROR";
      6:       return "CAN ERROR|";
      7:       return "ERRERROR";
      8:       return "NNO DATA";
      9:       return "no data";
      10:      return "UNABLE TO CONNEC";
      11:      return "ERROR|NO DATA";
      12:      return "UNABLE TO CONNECT ?";
      default: return "STOPPED";
    endcase
  endfunction

  function automatic reply_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 40) return RK_OK;
    if (r < 50) return RK_TEXT;
    if (r < 55) return RK_BLANK;
    if (r < 62) return RK_LONE;
    if (r < 70) return RK_BAD_SECOND;
    if (r < 77) return RK_BAD_FIRST;
    if (r < 84) return RK_LONG;
    if (r < 92) return RK_NOISE;
    return RK_TWO_LINES;
  endfunction

  // Append one character to the reply being built
  task automatic add_char(logic [7:0] c);
    reply_chars = {reply_chars, c};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char((s[i] == "|") ? CH_CR : s[i]);
  endtask

  task automatic add_pairs(int n, bit spaced);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      add_char(hex_digit(b[7:4], 1'($urandom_range(1))));
      add_char(hex_digit(b[3:0], 1'($urandom_range(1))));
      if (spaced && i != n - 1) add_char(CH_SPACE);
    end
  endtask

  // Line ending, maybe a prompt and some ignored characters after it
  task automatic add_end_of_line();
    case ($urandom_range(0, 3))
      0: ;
      1: add_char(CH_CR);
      2: add_text("||>");
      default: begin
        add_text(" |");
        add_char(CH_LF);
        add_char(CH_PROMPT);
        repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic build_reply(reply_kind_t kind);
    reply_chars.delete();
    case (kind)
      RK_OK: begin
        if ($urandom_range(1)) begin
          add_pairs(2, 1'b1);
          add_char(CH_CR);
        end
        add_pairs(byte_count(), 1'($urandom_range(1)));
        add_end_of_line();
      end
      RK_TEXT: begin
        add_text(canned_text($urandom_range(0, 13)));
        add_end_of_line();
      end
      RK_BLANK: begin
        repeat ($urandom_range(0, 4)) add_char(ws_char());
      end
      RK_LONE: begin
        // single digit, either mid-line or at the end
        add_pairs($urandom_range(1, 5), 1'b1);
        add_char(CH_SPACE);
        add_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(1))));
        if ($urandom_range(1)) begin
          add_char(CH_SPACE);
          add_pairs($urandom_range(1, 3), 1'b1);
        end
        repeat ($urandom_range(0, 2)) add_char(ws_char());
      end
      RK_BAD_SECOND: begin
        add_pairs($urandom_range(1, 4), 1'b0);
        add_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(1))));
        add_char(($urandom_range(3) == 0) ? CH_SPACE : non_hex_char());
        add_pairs($urandom_range(0, 4), 1'b0);
      end
      RK_BAD_FIRST: begin
        add_char(non_hex_char());
        add_pairs($urandom_range(1, 4), 1'b1);
        // a later line may replace the broken one
        if ($urandom_range(1)) begin
          add_char(CH_CR);
          add_pairs(byte_count(), 1'b1);
        end
      end
      RK_LONG: begin
        add_pairs($urandom_range(14, 20), 1'($urandom_range(1)));
        add_end_of_line();
      end
      RK_NOISE: begin
        repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(0, 255)));
      end
      default: begin
        add_pairs(byte_count(), 1'b1);
        add_char(CH_CR);
        if ($urandom_range(1)) add_char(($urandom_range(1)) ? CH_LF : CH_CR);
        add_pairs(byte_count(), 1'b1);
        add_end_of_line();
      end
    endcase
  endtask

  // One word on the character channel; called and returns at a falling edge
  task automatic send_word(logic [7:0] c, logic cv, logic eor);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.char_valid   <= cv;
    in_ch.end_of_reply <= eor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Reply with stray empty words; closed by its last character or an empty word
  task automatic send_reply();
    int n;
    bit close_on_last;
    n             = reply_chars.size();
    close_on_last = (n > 0) && $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(reply_chars[i], 1'b1, close_on_last && i == n - 1);
    end
    if (!close_on_last) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    replies_sent++;
  endtask

  // Hold the sender off until every expected word has come out
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int phase_start;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = 8'h00;
    in_ch.char_valid   = 1'b0;
    in_ch.end_of_reply = 1'b0;
    rst_n              = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty reply, bare '?', mode and pid only, both letter cases
    // with a prompt, lone digit, too few bytes
    send_word(8'h00, 1'b0, 1'b1);
    send_text("?");
    send_text("410C");
    send_text("ff00Ab>Z");
    send_text("00 1");
    send_text("1G");
    replies_sent += 6;

    // Random replies under each pacing mix
    for (int p = 0; p < N_PHASES; p++) begin
      wait_for_results();
      src_idle_pct   = SRC_IDLE[PW'(p)];
      sink_stall_pct = SINK_STALL[PW'(p)];
      phase_start    = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_reply(pick_kind());
        send_reply();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb: %0d replies, %0d character words, %0d result words checked",
             replies_sent, items_sent, results_seen);
    $display("tb: search strings, hex pair faults, line breaks, byte limits, 4 pacing mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/obdp_pkg.sv
rtl/obdp_ifs.sv
rtl/obdp_parser.sv
rtl/obdp_emitter.sv
rtl/obd_ascii_response_parser.sv
tb/obd_reply_checker.sv
tb/obd_ascii_response_parser_tb.sv
